/* design/fvc_pkg.sv */
// ----------------------------------------------------------------------------
// fvc_pkg
// Shared constants and types for the valid-region FIR convolution core.
// ----------------------------------------------------------------------------
package fvc_pkg;

  localparam int MAX_HALF    = 31;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 18;
  localparam int COEF_FRAC   = 16;

  localparam int DEPTH  = 2 * MAX_HALF + 1;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int HW_W   = 5;
  localparam int OUT_W  = 32;
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + IDX_W;
  localparam int SH_W   = ACC_W - COEF_FRAC;
  localparam int CMP_W  = ((SH_W > OUT_W) ? SH_W : OUT_W) + 1;
  localparam int CNT_W  = $clog2(DEPTH + 3);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // request opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register index (paddr[2])
  localparam logic REG_HALF_WIDTH = 1'b0;

  typedef struct packed {
    logic shift;   // take the newer neighbor's sample
    logic rotate;  // take the older neighbor's sample
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic valid;   // operands carry a live tap
  } mac_ctrl_t;

endpackage

/* design/fvc_ram.sv */
// ----------------------------------------------------------------------------
// fvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/fvc_cell.sv */
// ----------------------------------------------------------------------------
// fvc_cell
// One window slot: shifts toward older on a new sample, rotates toward newer
// while the taps are walked past the multiplier.
// ----------------------------------------------------------------------------
module fvc_cell (
  input  logic                                  clk,
  input  fvc_pkg::cell_ctrl_t                   ctrl,
  input  logic signed [fvc_pkg::SAMPLE_BITS-1:0] from_newer,
  input  logic signed [fvc_pkg::SAMPLE_BITS-1:0] from_older,
  output logic signed [fvc_pkg::SAMPLE_BITS-1:0] sample
);
  import fvc_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      sample <= from_newer;
    end else if (ctrl.rotate) begin
      sample <= from_older;
    end
  end

endmodule

/* design/fvc_mac.sv */
// ----------------------------------------------------------------------------
// fvc_mac
// Shared multiply-accumulate with floor scaling and 32-bit saturation.
// ----------------------------------------------------------------------------
module fvc_mac (
  input  logic                                   clk,
  input  fvc_pkg::mac_ctrl_t                     ctrl,
  input  logic signed [fvc_pkg::SAMPLE_BITS-1:0] sample,
  input  logic signed [fvc_pkg::COEF_BITS-1:0]   coef,
  output logic signed [fvc_pkg::OUT_W-1:0]       filtered_value,
  output logic                                   saturated
);
  import fvc_pkg::*;

  localparam logic signed [CMP_W-1:0] SAT_MAX =
    {{(CMP_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [CMP_W-1:0] SAT_MIN =
    {{(CMP_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SH_W-1:0]   shifted;
  logic signed [CMP_W-1:0]  shifted_ext;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(coef) * PROD_W'(sample);
    if (ctrl.clear) begin
      prod_valid <= 1'b0;
      acc        <= '0;
    end else begin
      prod_valid <= ctrl.valid;
      if (prod_valid) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // floor toward minus infinity, then clip
  assign shifted     = SH_W'(acc >>> COEF_FRAC);
  assign shifted_ext = CMP_W'(shifted);

  always_comb begin
    if (shifted_ext > SAT_MAX) begin
      filtered_value = SAT_MAX[OUT_W-1:0];
      saturated      = 1'b1;
    end else if (shifted_ext < SAT_MIN) begin
      filtered_value = SAT_MIN[OUT_W-1:0];
      saturated      = 1'b1;
    end else begin
      filtered_value = shifted_ext[OUT_W-1:0];
      saturated      = 1'b0;
    end
  end

endmodule

/* design/fir_valid_convolution_core.sv */
// ----------------------------------------------------------------------------
// fir_valid_convolution_core
// Streaming FIR filter over a rotating chain of window cells and one MAC.
// ----------------------------------------------------------------------------
//   channel   handshake                 payload
//   cfg       psel/penable/pwrite/pready paddr, pwdata, prdata
//   in        in_valid / in_ready        op, coef_index, coef_value,
//                                        sample_value, last
//   out       out_valid / out_ready      filtered_value, saturated, out_last
//
// A coefficient load or a sample that does not complete a window is taken
// while idle and leaves the core idle. A sample with a full window rotates
// the 63-cell window once around past the single MAC: the accept, the
// rotation, then the tap and coefficient registers, product register and
// accumulator; no new request is taken until the sum enters the output register.
// Synchronous reset clears control and the fill count; window cells and the
// coefficient RAM hold garbage until written. The output register lets the
// next request enter while a result waits; a finished sum waits in place
// only while that register is still occupied.
// ----------------------------------------------------------------------------
module fir_valid_convolution_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [fvc_pkg::PADDR_W-1:0]             paddr,
  input  logic [fvc_pkg::PDATA_W-1:0]             pwdata,
  output logic [fvc_pkg::PDATA_W-1:0]             prdata,
  output logic                                    pready,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    op,
  input  logic [fvc_pkg::IDX_W-1:0]               coef_index,
  input  logic signed [fvc_pkg::COEF_BITS-1:0]    coef_value,
  input  logic signed [fvc_pkg::SAMPLE_BITS-1:0]  sample_value,
  input  logic                                    last,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [fvc_pkg::OUT_W-1:0]        filtered_value,
  output logic                                    saturated,
  output logic                                    out_last
);
  import fvc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_HOLD
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         cnt;
  logic [IDX_W-1:0]         fill;
  logic [IDX_W-1:0]         fill_next;
  logic [HW_W-1:0]          half_width;
  logic [HW_W-1:0]          hw_eff;
  logic [IDX_W-1:0]         taps;
  logic                     rec_last;
  logic                     tap_valid;
  logic signed [SAMPLE_BITS-1:0] tap_sample;

  logic                     accept;
  logic                     accept_sample;
  logic                     rotating;
  logic [IDX_W-1:0]         step;
  logic                     live;
  logic [IDX_W-1:0]         coef_raddr;
  logic                     sum_done;
  logic                     out_free;
  logic                     out_load;
  logic                     cfg_write;

  logic signed [SAMPLE_BITS-1:0] win [DEPTH];
  cell_ctrl_t               cell_ctrl;
  mac_ctrl_t                mac_ctrl;
  logic [COEF_BITS-1:0]     coef_rdata;
  logic signed [OUT_W-1:0]  mac_value;
  logic                     mac_sat;

  // ---------------- configuration ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_HALF_WIDTH: half_width <= pwdata[HW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HALF_WIDTH: prdata = PDATA_W'(half_width);
      default:        prdata = '0;
    endcase
  end

  assign hw_eff = (half_width > HW_W'(MAX_HALF)) ? HW_W'(MAX_HALF) : half_width;
  assign taps   = IDX_W'(2 * hw_eff + 1);

  // ---------------- request side ----------------
  assign in_ready      = (state == S_IDLE);
  assign accept        = in_valid && in_ready;
  assign accept_sample = accept && (op == OP_SAMPLE);
  assign fill_next     = (fill < IDX_W'(DEPTH)) ? IDX_W'(fill + 1'b1) : fill;

  // ---------------- window chain ----------------
  assign rotating         = (state == S_CALC) && (cnt < CNT_W'(DEPTH));
  assign cell_ctrl.shift  = accept_sample;
  assign cell_ctrl.rotate = rotating;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] newer;
    logic signed [SAMPLE_BITS-1:0] older;
    if (i == 0) begin : g_head
      assign newer = sample_value;
    end else begin : g_body
      assign newer = win[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign older = win[0];
    end else begin : g_inner
      assign older = win[i+1];
    end
    fvc_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .from_newer (newer),
      .from_older (older),
      .sample     (win[i])
    );
  end

  // cell 0 holds sample[step]; it pairs with coefficient taps-1-step
  assign step       = cnt[IDX_W-1:0];
  assign live       = rotating && (step < taps);
  assign coef_raddr = IDX_W'(taps - 1'b1 - step);

  fvc_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (accept && (op == OP_LOAD) && (coef_index < IDX_W'(DEPTH))),
    .waddr (coef_index),
    .wdata (coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  assign mac_ctrl.clear = accept_sample;
  assign mac_ctrl.valid = tap_valid;

  fvc_mac u_mac (
    .clk            (clk),
    .ctrl           (mac_ctrl),
    .sample         (tap_sample),
    .coef           ($signed(coef_rdata)),
    .filtered_value (mac_value),
    .saturated      (mac_sat)
  );

  // ---------------- sequencer and output register ----------------
  assign sum_done = (cnt == CNT_W'(DEPTH + 2));
  assign out_free = !out_valid || out_ready;
  assign out_load = (((state == S_CALC) && sum_done) || (state == S_HOLD)) && out_free;

  always_ff @(posedge clk) begin
    tap_sample <= win[0];
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      fill      <= '0;
      rec_last  <= 1'b0;
      tap_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      tap_valid <= live;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept_sample) begin
            fill     <= last ? '0 : fill_next;
            rec_last <= last;
            if (fill_next >= taps) begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (sum_done) begin
            if (out_free) begin
              filtered_value <= mac_value;
              saturated      <= mac_sat;
              out_last       <= rec_last;
              state          <= S_IDLE;
            end else begin
              state <= S_HOLD;
            end
          end else begin
            cnt <= CNT_W'(cnt + 1'b1);
          end
        end
        S_HOLD: begin
          // hold the sum until the output register frees up
          if (out_free) begin
            filtered_value <= mac_value;
            saturated      <= mac_sat;
            out_last       <= rec_last;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/fir_valid_convolution_checker.sv */
// ----------------------------------------------------------------------------
// fir_valid_convolution_checker
// Watches the register port and both streams of the FIR core, keeps its own
// copy of the coefficients, the sample window and the record fill, predicts
// every filtered output and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module fir_valid_convolution_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [fvc_pkg::PADDR_W-1:0]             paddr,
  input  logic [fvc_pkg::PDATA_W-1:0]             pwdata,
  input  logic                                    pready,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic                                    op,
  input  logic [fvc_pkg::IDX_W-1:0]               coef_index,
  input  logic signed [fvc_pkg::COEF_BITS-1:0]    coef_value,
  input  logic signed [fvc_pkg::SAMPLE_BITS-1:0]  sample_value,
  input  logic                                    last,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic signed [fvc_pkg::OUT_W-1:0]        filtered_value,
  input  logic                                    saturated,
  input  logic                                    out_last,
  output int                                      fail_count,
  output int                                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import fvc_pkg::*;

  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (OUT_W - 1));

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    clipped;
    logic                    last;
  } fir_output_t;

  fir_output_t                   expected_outputs[$];
  logic signed [COEF_BITS-1:0]   tap_weight[DEPTH];
  logic signed [SAMPLE_BITS-1:0] sample_history[DEPTH];  // entry 0 is newest
  int unsigned                   record_fill;
  logic [HW_W-1:0]               half_width;
  int                            errors = 0;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      tap_weight[i]     = '0;
      sample_history[i] = '0;
    end
  end

  // Shift one sample in; return 1 with the filtered output once the window
  // of the current record is full.
  function automatic bit shift_in_sample(input logic signed [SAMPLE_BITS-1:0] sv,
                                         input logic lst, output fir_output_t res);
    int unsigned       n;
    int unsigned       taps;
    logic signed [63:0] acc;
    logic signed [63:0] weight;
    logic signed [63:0] sample;
    logic signed [63:0] scaled;
    res = '0;
    for (int i = DEPTH - 1; i > 0; i--) sample_history[i] = sample_history[i-1];
    sample_history[0] = sv;
    if (record_fill < DEPTH) record_fill++;
    n    = (half_width > MAX_HALF) ? MAX_HALF : half_width;
    taps = 2 * n + 1;
    if (record_fill < taps) begin
      if (lst) record_fill = 0;
      return 0;
    end
    acc = '0;
    for (int k = 0; k < taps; k++) begin
      weight = tap_weight[k];
      sample = sample_history[taps-1-k];
      acc    = acc + weight * sample;
    end
    // arithmetic shift rounds toward minus infinity
    scaled = acc >>> COEF_FRAC;
    if (scaled > OUT_MAX) begin
      scaled      = OUT_MAX;
      res.clipped = 1'b1;
    end else if (scaled < OUT_MIN) begin
      scaled      = OUT_MIN;
      res.clipped = 1'b1;
    end
    res.value = scaled[OUT_W-1:0];
    res.last  = lst;
    if (lst) record_fill = 0;
    return 1;
  endfunction

  task automatic report_field(input string field, input longint want, input longint got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    fir_output_t want;
    if (rst) begin
      expected_outputs.delete();
      record_fill = 0;
      half_width  = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t ns: unexpected output, expected none, got %0d", $time,
                   filtered_value);
          errors++;
        end else begin
          want = expected_outputs.pop_front();
          if (filtered_value !== want.value)
            report_field("filtered_value", want.value, filtered_value);
          if (saturated !== want.clipped)
            report_field("saturated", want.clipped, saturated);
          if (out_last !== want.last)
            report_field("out_last", want.last, out_last);
        end
      end
      if (in_valid && in_ready) begin
        if (op == OP_LOAD) begin
          // drop loads beyond the store
          if (coef_index < DEPTH) tap_weight[coef_index] = coef_value;
        end else if (shift_in_sample(sample_value, last, want)) begin
          expected_outputs.push_back(want);
        end
      end
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_HALF_WIDTH)
        half_width = pwdata[HW_W-1:0];
    end
    fail_count  <= errors;
    outstanding <= expected_outputs.size();
  end

endmodule

/* verif/tb_fir_valid_convolution_core.sv */
// ----------------------------------------------------------------------------
// tb_fir_valid_convolution_core
// Drives coefficient loads, sample records and half-width changes into the
// FIR core with random idling on both streams, long output stalls and full
// drains between register writes; the checker does all comparison.
// ----------------------------------------------------------------------------
module tb_fir_valid_convolution_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fvc_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 500;

  localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [PADDR_W-1:0]            paddr;
  logic [PDATA_W-1:0]            pwdata;
  logic [PDATA_W-1:0]            prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_ready;
  logic                          op;
  logic [IDX_W-1:0]              coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          last;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [OUT_W-1:0]       filtered_value;
  logic                          saturated;
  logic                          out_last;

  int fail_count;
  int outstanding;
  int results_seen = 0;
  int stall_cycles = 0;
  int random_items = 0;
  bit sender_calm  = 0;
  bit [DEPTH-1:0] coef_loaded = '0;

  fir_valid_convolution_core dut (.*);

  fir_valid_convolution_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen <= results_seen + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output side: random back-pressure, two long hold-offs, one calm stretch.
  initial begin : sink
    int hold_at;
    hold_at   = 40;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (results_seen >= hold_at) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_at = (hold_at == 40) ? 150 : 32'h7fff_ffff;
      end
      if (results_seen >= 200 && results_seen < 300)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(0, 99) >= 28);
    end
  end

  task automatic send_request(input logic o, input int idx, input int cv, input int sv,
                              input logic lst);
    int gap;
    @(negedge clk);
    if (!sender_calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    coef_index   <= IDX_W'(idx);
    coef_value   <= COEF_BITS'(cv);
    sample_value <= SAMPLE_BITS'(sv);
    last         <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Wait for every expected output, then let a request that yields none finish.
  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_half_width(input int unsigned n);
    logic [PDATA_W-1:0] data;
    data            = $urandom;
    data[HW_W-1:0]  = n[HW_W-1:0];
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_HALF_WIDTH, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned n;
    int          phase;
    int          len;
    int          last_odds;
    int          pick;
    int          idx;
    int          cv;
    int          sv;

    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    op           = OP_LOAD;
    coef_index   = '0;
    coef_value   = '0;
    sample_value = '0;
    last         = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // single tap at reset: extreme weights against extreme samples
    send_request(OP_LOAD, 0, int'(COEF_MAX), $urandom, 1'b0);
    send_request(OP_SAMPLE, $urandom, $urandom, int'(SAMPLE_MAX), 1'b0);
    send_request(OP_SAMPLE, $urandom, $urandom, int'(SAMPLE_MIN), 1'b0);
    send_request(OP_SAMPLE, $urandom, $urandom, 0, 1'b1);
    send_request(OP_LOAD, 0, int'(COEF_MIN), $urandom, 1'b1);
    send_request(OP_SAMPLE, $urandom, $urandom, int'(SAMPLE_MIN), 1'b0);
    send_request(OP_SAMPLE, $urandom, $urandom, int'(SAMPLE_MAX), 1'b1);
    // load past the end of the store must leave coefficient 0 alone
    send_request(OP_LOAD, -1, -1, $urandom, 1'b1);
    send_request(OP_SAMPLE, $urandom, $urandom, 3, 1'b0);
    send_request(OP_LOAD, 1, 1 << COEF_FRAC, $urandom, 1'b0);
    send_request(OP_LOAD, 2, -1, $urandom, 1'b0);
    coef_loaded[2:0] = '1;
    drain_outputs();
    write_half_width(1);
    // record ended before the window filled, then a new record fills it
    send_request(OP_SAMPLE, $urandom, $urandom, 5, 1'b1);
    send_request(OP_SAMPLE, $urandom, $urandom, -1, 1'b0);
    send_request(OP_SAMPLE, $urandom, $urandom, 7, 1'b0);
    send_request(OP_SAMPLE, $urandom, $urandom, 100, 1'b0);
    send_request(OP_SAMPLE, $urandom, $urandom, int'(SAMPLE_MAX), 1'b0);
    // narrow, then widen again inside the same record
    drain_outputs();
    write_half_width(0);
    send_request(OP_SAMPLE, $urandom, $urandom, -2, 1'b0);
    drain_outputs();
    write_half_width(1);
    send_request(OP_SAMPLE, $urandom, $urandom, 9, 1'b1);

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (phase == 0)      n = MAX_HALF;
      else if (phase == 1) n = 0;
      else if (pick < 25)  n = 0;
      else if (pick < 40)  n = MAX_HALF;
      else if (pick < 75)  n = $urandom_range(1, 4);
      else                 n = $urandom_range(0, MAX_HALF);
      drain_outputs();
      write_half_width(n);
      // every tap in use must be loaded before a sample reaches it
      for (int i = 0; i <= 2 * n; i++) begin
        if (!coef_loaded[i]) begin
          send_request(OP_LOAD, i, $urandom, $urandom, 1'($urandom_range(0, 1)));
          coef_loaded[i] = 1'b1;
          random_items++;
        end
      end
      len       = (n >= 16) ? $urandom_range(80, 140) : $urandom_range(20, 60);
      last_odds = (n >= 16) ? 200 : 12;
      for (int j = 0; j < len; j++) begin
        sender_calm = (random_items >= 200 && random_items < 280);
        pick        = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < 15) begin
          idx = $urandom_range(0, (1 << IDX_W) - 1);
          cv  = (pick == 0) ? int'(COEF_MAX) : (pick == 1) ? int'(COEF_MIN) : $urandom;
          send_request(OP_LOAD, idx, cv, $urandom, 1'($urandom_range(0, 1)));
          if (idx < DEPTH) coef_loaded[idx] = 1'b1;
        end else begin
          sv = (pick == 0) ? int'(SAMPLE_MAX) : (pick == 1) ? int'(SAMPLE_MIN) : $urandom;
          send_request(OP_SAMPLE, $urandom, $urandom, sv,
                       $urandom_range(0, last_odds - 1) == 0);
        end
        random_items++;
      end
      sender_calm = 0;
      phase++;
    end

    drain_outputs();
    if (fail_count == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
